[rtl/button_debounce_autorepeat_unit_macros.svh]
// Assertion macros shared by the debounce and auto-repeat RTL.
`ifndef BUTTON_DEBOUNCE_AUTOREPEAT_UNIT_MACROS_SVH
`define BUTTON_DEBOUNCE_AUTOREPEAT_UNIT_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define BDA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bda assertion failed");

// Next-cycle implication, checked only outside reset.
`define BDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bda assertion failed");

`endif

[rtl/bda_pkg.sv]
// Types and constants for the button debounce and auto-repeat unit.
package bda_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_MS       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY_MS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD_MS = 2'd2;

  localparam logic [CFG_DATA_W-1:0] LOCKOUT_MS_RESET       = 16'd50;
  localparam logic [CFG_DATA_W-1:0] REPEAT_DELAY_MS_RESET  = 16'd500;
  localparam logic [CFG_DATA_W-1:0] REPEAT_PERIOD_MS_RESET = 16'd100;

  typedef struct packed {
    logic [3:0]  direction_levels;
    logic [3:0]  action_levels;
    logic [31:0] now_ms;
  } bda_in_t;

  typedef struct packed {
    logic       direction_event;
    logic [3:0] direction_bits;
    logic [3:0] press_mask;
    logic [3:0] release_mask;
    logic       locked_out;
  } bda_out_t;

endpackage

[rtl/button_debounce_autorepeat_unit.sv]
// Button debounce with shared lockout window and direction auto-repeat.
// An input transfer is registered in the input stage, then its result in the result register.
// One sample per cycle unless a low out_ready holds the result; the state update is a single registered pass.
// The input register and the result register each hold one item.
// Reset (synchronous, rst_n low) clears the history and timers and loads the
// default lockout, repeat delay and repeat period.
`include "button_debounce_autorepeat_unit_macros.svh"

module button_debounce_autorepeat_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  bda_pkg::bda_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output bda_pkg::bda_out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [bda_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bda_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  // Configuration registers.
  logic [bda_pkg::CFG_DATA_W-1:0] lockout_ms_r;
  logic [bda_pkg::CFG_DATA_W-1:0] repeat_delay_ms_r;
  logic [bda_pkg::CFG_DATA_W-1:0] repeat_period_ms_r;

  // Input stage and result stage.
  logic              s1_valid_r;
  bda_pkg::bda_in_t  s1_data_r;
  logic              out_valid_r;
  bda_pkg::bda_out_t out_data_r;

  // Sample history and timers.
  logic [7:0]  prev_levels_r;
  logic [31:0] lockout_start_r;
  logic        repeat_active_r;
  logic [31:0] hold_start_r;
  logic [31:0] last_repeat_r;

  logic [7:0]  prev_levels_nxt;
  logic [31:0] lockout_start_nxt;
  logic        repeat_active_nxt;
  logic [31:0] hold_start_nxt;
  logic [31:0] last_repeat_nxt;
  bda_pkg::bda_out_t result;

  logic        advance;
  logic        in_xfer;
  logic [3:0]  dir;
  logic [3:0]  act;
  logic [31:0] now;
  logic [31:0] lock_age;
  logic [31:0] hold_age;
  logic [31:0] repeat_age;
  logic        locked;
  logic        same_dir;
  logic        fire_first;
  logic        fire_repeat;
  logic        fire;
  logic [3:0]  press;
  logic [3:0]  release_m;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign dir = s1_data_r.direction_levels;
  assign act = s1_data_r.action_levels;
  assign now = s1_data_r.now_ms;

  // Modular differences keep the comparisons correct across clock wrap.
  assign lock_age   = now - lockout_start_r;
  assign hold_age   = now - hold_start_r;
  assign repeat_age = now - last_repeat_r;
  assign locked     = lock_age <= {16'd0, lockout_ms_r};

  assign same_dir    = (dir != 4'd0) && (dir == prev_levels_r[3:0]);
  assign fire_first  = !locked && same_dir && !repeat_active_r;
  assign fire_repeat = !locked && same_dir && repeat_active_r &&
                       (hold_age > {16'd0, repeat_delay_ms_r}) &&
                       (repeat_age > {16'd0, repeat_period_ms_r});
  assign fire        = fire_first || fire_repeat;

  assign press     = act & ~prev_levels_r[7:4];
  assign release_m = ~act & prev_levels_r[7:4];

  always_comb begin
    prev_levels_nxt   = prev_levels_r;
    lockout_start_nxt = lockout_start_r;
    repeat_active_nxt = repeat_active_r;
    hold_start_nxt    = hold_start_r;
    last_repeat_nxt   = last_repeat_r;
    result            = '0;
    if (locked) begin
      result.locked_out = 1'b1;
    end else begin
      prev_levels_nxt = {act, dir};
      if (dir == 4'd0) begin
        repeat_active_nxt = 1'b0;
      end else if (fire_first) begin
        repeat_active_nxt = 1'b1;
        hold_start_nxt    = now;
      end
      if (fire) begin
        last_repeat_nxt = now;
      end
      // A first direction event and any action edge both reopen the lockout.
      if (fire_first || (|(press | release_m))) begin
        lockout_start_nxt = now;
      end
      result.direction_event = fire;
      result.direction_bits  = fire ? dir : 4'd0;
      result.press_mask      = press;
      result.release_mask    = release_m;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lockout_ms_r       <= bda_pkg::LOCKOUT_MS_RESET;
      repeat_delay_ms_r  <= bda_pkg::REPEAT_DELAY_MS_RESET;
      repeat_period_ms_r <= bda_pkg::REPEAT_PERIOD_MS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bda_pkg::CFG_LOCKOUT_MS:       lockout_ms_r       <= cfg_wdata;
        bda_pkg::CFG_REPEAT_DELAY_MS:  repeat_delay_ms_r  <= cfg_wdata;
        bda_pkg::CFG_REPEAT_PERIOD_MS: repeat_period_ms_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      prev_levels_r   <= '0;
      lockout_start_r <= '0;
      repeat_active_r <= 1'b0;
      hold_start_r    <= '0;
      last_repeat_r   <= '0;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r     <= 1'b1;
        prev_levels_r   <= prev_levels_nxt;
        lockout_start_r <= lockout_start_nxt;
        repeat_active_r <= repeat_active_nxt;
        hold_start_r    <= hold_start_nxt;
        last_repeat_r   <= last_repeat_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= result;
    end
  end

  `BDA_ASSERT_IMPL(a_locked_result_clean, clk, rst_n,
    out_valid_r && out_data_r.locked_out,
    !out_data_r.direction_event && out_data_r.direction_bits == 4'd0 &&
    out_data_r.press_mask == 4'd0 && out_data_r.release_mask == 4'd0)
  `BDA_ASSERT_IMPL(a_event_has_bits, clk, rst_n,
    out_valid_r && out_data_r.direction_event, out_data_r.direction_bits != 4'd0)
  `BDA_ASSERT_NEXT(a_locked_keeps_state, clk, rst_n,
    advance && locked,
    $stable(prev_levels_r) && $stable(lockout_start_r) && $stable(repeat_active_r))
  `BDA_ASSERT_IMPL(a_edges_disjoint, clk, rst_n,
    out_valid_r, (out_data_r.press_mask & out_data_r.release_mask) == 4'd0)

endmodule
